@@ rtl/core/ndopt_pkg.sv @@
// Shared types and constants for the neighbor discovery option parser.
// No dependencies.
package ndopt_pkg;

  localparam int unsigned MaxAreaBytes = 2048;
  localparam int unsigned PosW         = $clog2(MaxAreaBytes + 1);
  localparam int unsigned OffW         = 11;
  localparam int unsigned LeftW        = 11;
  localparam int unsigned NumRec       = 6;
  localparam int unsigned MaskW        = 5;

  // slots of the recorded offset array
  localparam int unsigned RecSrc      = 0;
  localparam int unsigned RecTgt      = 1;
  localparam int unsigned RecPfxFirst = 2;
  localparam int unsigned RecRedir    = 3;
  localparam int unsigned RecMtu      = 4;
  localparam int unsigned RecPfxLast  = 5;

  // option type codes
  localparam logic [7:0] OptSrcLl  = 8'd1;
  localparam logic [7:0] OptTgtLl  = 8'd2;
  localparam logic [7:0] OptPrefix = 8'd3;
  localparam logic [7:0] OptRedir  = 8'd4;
  localparam logic [7:0] OptMtu    = 8'd5;

  // present mask bits
  localparam int unsigned BitSrc    = 0;
  localparam int unsigned BitTgt    = 1;
  localparam int unsigned BitPrefix = 2;
  localparam int unsigned BitRedir  = 3;
  localparam int unsigned BitMtu    = 4;

  typedef enum logic [1:0] {
    PhType = 2'd0,
    PhLen  = 2'd1,
    PhBody = 2'd2
  } phase_e;

  typedef struct packed {
    logic                          area_valid;
    logic [MaskW-1:0]              present_mask;
    logic [NumRec-1:0][OffW-1:0]   offs;
    logic [1:0]                    len_ok;
  } ndopt_sum_t;

endpackage

@@ rtl/core/ndopt_walker.sv @@
// Option walk state for the neighbor discovery option parser: one byte per step,
// summary of the area after that byte. Depends on ndopt_pkg.
module ndopt_walker import ndopt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  input  logic       empty_i,
  output ndopt_sum_t sum_o
);

  logic [PosW-1:0]             pos_q, pos_d;
  logic [LeftW-1:0]            left_q, left_d;
  phase_e                      phase_q, phase_d;
  logic [7:0]                  type_q, type_d;
  logic [OffW-1:0]             start_q, start_d;
  logic                        err_q, err_d;
  logic [MaskW-1:0]            found_q, found_d;
  logic [NumRec-1:0][OffW-1:0] rec_q, rec_d;
  logic [1:0]                  lenok_q, lenok_d;
  logic [LeftW-1:0]            total;
  logic                        area_ok;

  always_comb begin
    pos_d   = pos_q;
    left_d  = left_q;
    phase_d = phase_q;
    type_d  = type_q;
    start_d = start_q;
    err_d   = err_q;
    found_d = found_q;
    rec_d   = rec_q;
    lenok_d = lenok_q;
    total   = {data_i, 3'b000};

    if (pos_q >= PosW'(MaxAreaBytes)) begin
      err_d = 1'b1;
    end else begin
      pos_d = pos_q + PosW'(1);
    end

    if (!err_d) begin
      unique case (phase_q)
        PhType: begin
          type_d  = data_i;
          start_d = OffW'(pos_q);
          phase_d = PhLen;
        end
        PhLen: begin
          if (data_i == 8'd0) begin
            err_d = 1'b1;
          end else begin
            unique case (type_q)
              OptSrcLl: begin
                if (!found_q[BitSrc]) begin
                  found_d[BitSrc] = 1'b1;
                  rec_d[RecSrc]   = start_q;
                  lenok_d[0]      = (data_i == 8'd1);
                end
              end
              OptTgtLl: begin
                if (!found_q[BitTgt]) begin
                  found_d[BitTgt] = 1'b1;
                  rec_d[RecTgt]   = start_q;
                  lenok_d[1]      = (data_i == 8'd1);
                end
              end
              OptPrefix: begin
                rec_d[RecPfxLast] = start_q;
                if (!found_q[BitPrefix]) begin
                  found_d[BitPrefix] = 1'b1;
                  rec_d[RecPfxFirst] = start_q;
                end
              end
              OptRedir: begin
                if (!found_q[BitRedir]) begin
                  found_d[BitRedir] = 1'b1;
                  rec_d[RecRedir]   = start_q;
                end
              end
              OptMtu: begin
                if (!found_q[BitMtu]) begin
                  found_d[BitMtu] = 1'b1;
                  rec_d[RecMtu]   = start_q;
                end
              end
              default: ;
            endcase
            left_d  = total - LeftW'(2);
            phase_d = (left_d == '0) ? PhType : PhBody;
          end
        end
        PhBody: begin
          if (left_q != '0) begin
            left_d = left_q - LeftW'(1);
          end
          if (left_d == '0) begin
            phase_d = PhType;
          end
        end
        default: ;
      endcase
    end
  end

  assign area_ok = !err_d && (phase_d == PhType);

  always_comb begin
    sum_o = '0;
    if (empty_i) begin
      sum_o.area_valid = 1'b1;
    end else if (area_ok) begin
      sum_o.area_valid   = 1'b1;
      sum_o.present_mask = found_d;
      sum_o.offs         = rec_d;
      sum_o.len_ok       = lenok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      left_q  <= '0;
      phase_q <= PhType;
      type_q  <= '0;
      start_q <= '0;
      err_q   <= 1'b0;
      found_q <= '0;
      rec_q   <= '0;
      lenok_q <= '0;
    end else if (step_i) begin
      if (last_i || empty_i) begin
        pos_q   <= '0;
        left_q  <= '0;
        phase_q <= PhType;
        type_q  <= '0;
        start_q <= '0;
        err_q   <= 1'b0;
        found_q <= '0;
        rec_q   <= '0;
        lenok_q <= '0;
      end else begin
        pos_q   <= pos_d;
        left_q  <= left_d;
        phase_q <= phase_d;
        type_q  <= type_d;
        start_q <= start_d;
        err_q   <= err_d;
        found_q <= found_d;
        rec_q   <= rec_d;
        lenok_q <= lenok_d;
      end
    end
  end

endmodule

@@ rtl/core/nd_option_tlv_parser.sv @@
// Top level of the neighbor discovery option parser: input word register,
// option walker and summary register. Depends on ndopt_pkg and ndopt_walker.

// Takes one option-area byte per word and accepts a new word every cycle, with no
// bubbles between areas, as long as each summary is taken when it is offered. A
// summary appears after the word that ends the area (last_byte_i or empty_area_i)
// is accepted: the word is first held in the input register, and the walker
// update loads the summary register as the word leaves it; the walker's state
// update on each word sets the rate of one word per clock. A summary still
// waiting on the output holds an area-ending word in the input register, and the
// input stalls until the summary is taken. Offsets are byte positions of an
// option's type byte within the area. An invalid area gives area_valid_o = 0 with
// all other summary fields zero.
module nd_option_tlv_parser import ndopt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic            empty_area_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            area_valid_o,
  output logic [4:0]      present_mask_o,
  output logic [OffW-1:0] source_ll_offset_o,
  output logic [OffW-1:0] target_ll_offset_o,
  output logic [OffW-1:0] mtu_offset_o,
  output logic [OffW-1:0] redirect_offset_o,
  output logic [OffW-1:0] prefix_first_offset_o,
  output logic [OffW-1:0] prefix_last_offset_o,
  output logic            source_ll_len_ok_o,
  output logic            target_ll_len_ok_o
);

  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_last_q;
  logic       s1_empty_q;
  logic       s1_emits;
  logic       s1_go;
  logic       out_free;
  logic       out_valid_q;
  ndopt_sum_t sum;
  ndopt_sum_t out_q;

  assign s1_emits   = s1_last_q || s1_empty_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_emits || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q  <= data_byte_i;
      s1_last_q  <= last_byte_i;
      s1_empty_q <= empty_area_i;
    end
  end

  ndopt_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_go),
    .data_i  (s1_data_q),
    .last_i  (s1_last_q),
    .empty_i (s1_empty_q),
    .sum_o   (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_emits) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emits) begin
      out_q <= sum;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign area_valid_o          = out_q.area_valid;
  assign present_mask_o        = out_q.present_mask;
  assign source_ll_offset_o    = out_q.offs[RecSrc];
  assign target_ll_offset_o    = out_q.offs[RecTgt];
  assign mtu_offset_o          = out_q.offs[RecMtu];
  assign redirect_offset_o     = out_q.offs[RecRedir];
  assign prefix_first_offset_o = out_q.offs[RecPfxFirst];
  assign prefix_last_offset_o  = out_q.offs[RecPfxLast];
  assign source_ll_len_ok_o    = out_q.len_ok[0];
  assign target_ll_len_ok_o    = out_q.len_ok[1];

`ifndef SYNTHESIS
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !area_valid_o |->
      present_mask_o == '0 && !source_ll_len_ok_o && !target_ll_len_ok_o)
    else $error("invalid area summary carries option data");

  a_lenok_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (source_ll_len_ok_o || target_ll_len_ok_o) |->
      (!source_ll_len_ok_o || present_mask_o[BitSrc]) &&
      (!target_ll_len_ok_o || present_mask_o[BitTgt]))
    else $error("link-layer length flag without option present");

  a_prefix_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !present_mask_o[BitPrefix] |->
      prefix_first_offset_o == '0 && prefix_last_offset_o == '0)
    else $error("prefix offsets set without prefix option");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q)
    else $error("input word dropped while stalled");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_emits |=> out_valid_o)
    else $error("area end did not produce a summary");
`endif

endmodule
